// File: rtl/core/drti_pkg.sv
// Package for the decimal round-to-integer block: widths, codes, sequencer
// state type and the control word passed from the sequencer to the datapath.
// No dependencies.
package drti_pkg;

  localparam int MAG_BITS   = 96;
  localparam int IN_MAG_W   = 96;
  localparam int MAG_W      = (MAG_BITS < IN_MAG_W) ? MAG_BITS : IN_MAG_W;
  localparam int LANE_W     = 32;
  localparam int NUM_LANES  = (MAG_W + LANE_W - 1) / LANE_W;
  localparam int MAG_TOT    = NUM_LANES * LANE_W;
  localparam int LANE_IDX_W = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
  localparam int SCALE_W    = 5;
  localparam int DIGIT_W    = 4;

  localparam logic [MAG_TOT-1:0] MAG_MASK = {MAG_TOT{1'b1}} >> (MAG_TOT - MAG_W);

  // floor(2^32 / 10), 2^32 mod 10, and ceil(2^36 / 10) for the lane divider
  localparam logic [LANE_W-1:0] DIV_HI    = 32'd429496729;
  localparam logic [2:0]        DIV_WRAP  = 3'd6;
  localparam logic [32:0]       DIV_RECIP = 33'd6871947674;
  localparam int                RECIP_SH  = 36;

  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_HALF = 4'd5;

  localparam int DATA_W = 104;
  localparam int IN_USER_W = 4;
  localparam int OUT_USER_W = 2;

  typedef enum logic [1:0] {
    KIND_TRUNC = 2'd0,
    KIND_FLOOR = 2'd1,
    KIND_ROUND = 2'd2,
    KIND_NEG   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CLS_NORMAL = 2'd0,
    CLS_PINF   = 2'd1,
    CLS_MINF   = 2'd2,
    CLS_NAN    = 2'd3
  } cls_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX
  } state_e;

  typedef struct packed {
    logic                  load;
    logic                  div_en;
    logic                  digit_end;
    logic                  fix;
    logic [LANE_IDX_W-1:0] lane;
  } ctl_t;

endpackage

// File: rtl/core/drti_div10.sv
// Shared divide-by-ten unit: one 32-bit lane plus incoming remainder per use.
// Uses drti_pkg constants; reciprocal multiply with a single 33x33 product.
module drti_div10 (
  input  logic [drti_pkg::DIGIT_W-1:0] rem_i,
  input  logic [drti_pkg::LANE_W-1:0]  lane_i,
  output logic [drti_pkg::LANE_W-1:0]  quo_o,
  output logic [drti_pkg::DIGIT_W-1:0] rem_o
);

  logic [32:0] y;
  logic [65:0] prod;
  logic [29:0] q_lo;
  logic [32:0] back;
  logic [32:0] diff;

  // (rem*2^32 + lane)/10 = rem*floor(2^32/10) + (rem*6 + lane)/10
  assign y    = 33'(lane_i) + 33'(rem_i) * 33'(drti_pkg::DIV_WRAP);
  assign prod = 66'(y) * 66'(drti_pkg::DIV_RECIP);
  assign q_lo = prod[65:drti_pkg::RECIP_SH];
  assign back = {q_lo, 3'b000} + {2'b00, q_lo, 1'b0};
  assign diff = y - back;

  assign quo_o = 32'(q_lo) + 32'(32'(rem_i) * drti_pkg::DIV_HI);
  assign rem_o = diff[drti_pkg::DIGIT_W-1:0];

endmodule

// File: rtl/core/drti_seq.sv
// Sequencer: walks the lanes of the magnitude once per dropped digit, then
// finishes the word. Depends on drti_pkg for state type and control word.
module drti_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         need_div_i,
  input  logic [drti_pkg::SCALE_W-1:0] scale_i,
  input  logic                         out_busy_i,
  output logic                         in_ready_o,
  output drti_pkg::ctl_t               ctl_o
);

  localparam logic [drti_pkg::LANE_IDX_W-1:0] LANE_TOP =
    drti_pkg::LANE_IDX_W'(drti_pkg::NUM_LANES - 1);

  drti_pkg::state_e state_q, state_d;
  logic [drti_pkg::SCALE_W-1:0]    digits_q, digits_d;
  logic [drti_pkg::LANE_IDX_W-1:0] lane_q, lane_d;
  logic last_lane;

  assign last_lane = (lane_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      drti_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = need_div_i ? drti_pkg::ST_DIV : drti_pkg::ST_FIX;
        end
      end
      drti_pkg::ST_DIV: begin
        if (last_lane && (digits_q == drti_pkg::SCALE_W'(1))) begin
          state_d = drti_pkg::ST_FIX;
        end
      end
      drti_pkg::ST_FIX: begin
        if (!out_busy_i) begin
          state_d = drti_pkg::ST_IDLE;
        end
      end
      default: state_d = drti_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == drti_pkg::ST_IDLE);
    ctl_o.load      = (state_q == drti_pkg::ST_IDLE) && in_valid_i;
    ctl_o.div_en    = (state_q == drti_pkg::ST_DIV);
    ctl_o.digit_end = (state_q == drti_pkg::ST_DIV) && last_lane;
    ctl_o.fix       = (state_q == drti_pkg::ST_FIX) && !out_busy_i;
    ctl_o.lane      = lane_q;
  end

  always_comb begin
    digits_d = digits_q;
    lane_d   = lane_q;
    if (ctl_o.load) begin
      digits_d = scale_i;
      lane_d   = LANE_TOP;
    end else if (ctl_o.div_en) begin
      if (last_lane) begin
        digits_d = digits_q - drti_pkg::SCALE_W'(1);
        lane_d   = LANE_TOP;
      end else begin
        lane_d = lane_q - drti_pkg::LANE_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= drti_pkg::ST_IDLE;
      digits_q <= '0;
      lane_q   <= '0;
    end else begin
      state_q  <= state_d;
      digits_q <= digits_d;
      lane_q   <= lane_d;
    end
  end

endmodule

// File: rtl/core/decimal_round_to_integer.sv
// Top level of the decimal round-to-integer block: datapath, output register.
// Instantiates drti_seq and drti_div10; uses drti_pkg.
//
// Usage: one word in on s_axis, one word out on m_axis, both valid/ready.
// An input word carries a 96-bit magnitude, scale, sign (tdata) and the
// operation and value class (tuser). Truncate, floor and round drop scale
// decimal digits and return scale 0; negate flips the sign. Non-normal
// classes pass through unchanged.
// Timing: the magnitude is divided by ten one 32-bit lane per cycle through a
// single shared divide unit. s_axis_tready is high only while the sequencer is
// idle; one item is in work at a time.
// The result sits in an output register; the next item may be accepted and
// worked on while it waits. If m_axis_tready stays low, the finished item
// holds in its last cycle until the register frees.
// Reset (rst_ni low, asynchronous) empties the output and idles the
// sequencer; the block is ready for input straight out of reset.
module decimal_round_to_integer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // mag_low[63:0], mag_high[95:64], scale_in[100:96], sign_in[101], zero[103:102]
  input  logic [drti_pkg::DATA_W-1:0]       s_axis_tdata,
  // kind[1:0], class_in[3:2]
  input  logic [drti_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // res_low[63:0], res_high[95:64], scale_out[100:96], sign_out[101], zero[103:102]
  output logic [drti_pkg::DATA_W-1:0]       m_axis_tdata,
  // class_out[1:0]
  output logic [drti_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

  localparam int MT = drti_pkg::MAG_TOT;
  localparam int LW = drti_pkg::LANE_W;
  localparam int DW = drti_pkg::DIGIT_W;

  drti_pkg::ctl_t ctl;

  drti_pkg::kind_e              in_kind;
  drti_pkg::cls_e               in_cls;
  logic [drti_pkg::SCALE_W-1:0] in_scale;
  logic                         need_div;
  logic                         out_busy;

  logic [MT-1:0]                mag_q, mag_d;
  logic [DW-1:0]                rem_q, rem_d;
  logic [DW-1:0]                top_q, top_d;
  logic                         sticky_q, sticky_d;
  drti_pkg::kind_e              kind_q;
  drti_pkg::cls_e               cls_q;
  logic [drti_pkg::SCALE_W-1:0] scale_q;
  logic                         sign_q;

  logic [drti_pkg::IN_MAG_W-1:0] res_q, res_d;
  logic [drti_pkg::SCALE_W-1:0]  oscale_q, oscale_d;
  logic                          osign_q, osign_d;
  drti_pkg::cls_e                ocls_q;
  logic                          m_valid_q, m_valid_d;

  logic [LW-1:0] div_lane, div_quo;
  logic [DW-1:0] div_rem;
  logic          round_up;
  logic [MT-1:0] mag_inc;

  assign in_kind  = drti_pkg::kind_e'(s_axis_tuser[1:0]);
  assign in_cls   = drti_pkg::cls_e'(s_axis_tuser[3:2]);
  assign in_scale = s_axis_tdata[100:96];
  assign need_div = (in_cls == drti_pkg::CLS_NORMAL) && (in_kind != drti_pkg::KIND_NEG) &&
                    (in_scale != '0);
  assign out_busy = m_valid_q && !m_axis_tready;

  drti_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .need_div_i (need_div),
    .scale_i    (in_scale),
    .out_busy_i (out_busy),
    .in_ready_o (s_axis_tready),
    .ctl_o      (ctl)
  );

  assign div_lane = mag_q[ctl.lane*LW +: LW];

  drti_div10 u_div (
    .rem_i  (rem_q),
    .lane_i (div_lane),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  always_comb begin
    mag_d    = mag_q;
    rem_d    = rem_q;
    top_d    = top_q;
    sticky_d = sticky_q;
    if (ctl.load) begin
      mag_d    = MT'(s_axis_tdata[drti_pkg::IN_MAG_W-1:0]) & drti_pkg::MAG_MASK;
      rem_d    = '0;
      top_d    = '0;
      sticky_d = 1'b0;
    end else if (ctl.div_en) begin
      mag_d[ctl.lane*LW +: LW] = div_quo;
      if (ctl.digit_end) begin
        rem_d    = '0;
        top_d    = div_rem;
        sticky_d = sticky_q || (top_q != '0);
      end else begin
        rem_d = div_rem;
      end
    end
  end

  // increment decision after the last dropped digit
  always_comb begin
    round_up = 1'b0;
    case (kind_q)
      drti_pkg::KIND_FLOOR:
        round_up = sign_q && (sticky_q || (top_q != '0));
      drti_pkg::KIND_ROUND:
        round_up = (top_q > drti_pkg::DIGIT_HALF) ||
                   ((top_q == drti_pkg::DIGIT_HALF) && (sticky_q || mag_q[0]));
      default: round_up = 1'b0;
    endcase
  end

  assign mag_inc = (mag_q + MT'(1)) & drti_pkg::MAG_MASK;

  always_comb begin
    res_d     = res_q;
    oscale_d  = oscale_q;
    osign_d   = osign_q;
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (ctl.fix) begin
      m_valid_d = 1'b1;
      res_d     = drti_pkg::IN_MAG_W'(mag_q);
      oscale_d  = scale_q;
      osign_d   = sign_q;
      if (cls_q == drti_pkg::CLS_NORMAL) begin
        if (kind_q == drti_pkg::KIND_NEG) begin
          osign_d = !sign_q;
        end else begin
          oscale_d = '0;
          if (round_up) begin
            res_d = drti_pkg::IN_MAG_W'(mag_inc);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      top_q     <= '0;
      sticky_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      rem_q     <= rem_d;
      top_q     <= top_d;
      sticky_q  <= sticky_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    res_q    <= res_d;
    oscale_q <= oscale_d;
    osign_q  <= osign_d;
    if (ctl.load) begin
      kind_q  <= in_kind;
      cls_q   <= in_cls;
      scale_q <= in_scale;
      sign_q  <= s_axis_tdata[101];
    end
    if (ctl.fix) begin
      ocls_q <= cls_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, osign_q, oscale_q, res_q};
  assign m_axis_tuser  = ocls_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  a_valid_from_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(ctl.fix))
    else $error("output valid without a finished item");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.digit_end |-> (div_rem < DW'(drti_pkg::DIGIT_TEN)))
    else $error("dropped digit out of range");

  a_sticky_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sticky_q) |-> $past(ctl.digit_end))
    else $error("sticky set outside a digit step");

endmodule

// File: test/decimal_round_to_integer_tb.sv
// Self-checking testbench for decimal_round_to_integer: drives scaled-decimal words on
// s_axis, predicts truncate/floor/round-half-even/negate results, checks m_axis.
// Depends on drti_pkg and the decimal_round_to_integer RTL.
module decimal_round_to_integer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TAIL_CYCLES  = 120;
  localparam int PRINT_LIMIT  = 40;
  localparam int RAND_CHUNKS  = 12;
  localparam int CHUNK_WORDS  = 150;
  localparam int HOLD_CYCLES  = 400;

  typedef enum logic [1:0] {
    SINK_ALWAYS,
    SINK_RANDOM,
    SINK_PATTERN
  } sink_mode_e;

  typedef struct packed {
    drti_pkg::kind_e kind;
    logic [95:0]     mag;
    logic [4:0]      scale;
    logic            sign;
    drti_pkg::cls_e  cls;
  } dec_word_t;

  typedef struct packed {
    logic [95:0]     mag;
    logic [4:0]      scale;
    logic            sign;
    drti_pkg::cls_e  cls;
  } dec_result_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [drti_pkg::DATA_W-1:0]      s_axis_tdata = '0;
  logic [drti_pkg::IN_USER_W-1:0]   s_axis_tuser = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [drti_pkg::DATA_W-1:0]      m_axis_tdata;
  logic [drti_pkg::OUT_USER_W-1:0]  m_axis_tuser;

  dec_result_t   pending_results[$];
  int            mismatch_cnt = 0;
  int            cycle_cnt = 0;
  bit            sender_gaps = 1'b0;
  int            burst_left = 0;
  sink_mode_e    sink_mode = SINK_ALWAYS;
  logic [15:0]   sink_pattern = 16'hffff;
  logic [3:0]    sink_phase = '0;
  int            hold_request = 0;
  int            hold_left = 0;

  decimal_round_to_integer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt,
               pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Drops scale digits one at a time; the last dropped digit decides, the rest is sticky.
  function automatic dec_result_t round_to_integer(dec_word_t w);
    dec_result_t r;
    logic [95:0] m;
    logic [3:0]  top;
    logic        sticky;
    logic        bump;
    m        = w.mag & drti_pkg::MAG_MASK;
    r.mag    = m;
    r.scale  = w.scale;
    r.sign   = w.sign;
    r.cls    = w.cls;
    if (w.cls == drti_pkg::CLS_NORMAL) begin
      if (w.kind == drti_pkg::KIND_NEG) begin
        r.sign = ~w.sign;
      end else begin
        top    = '0;
        sticky = 1'b0;
        for (int i = 0; i < w.scale; i++) begin
          sticky = sticky | (top != 0);
          top    = 4'(m % 10);
          m      = m / 10;
        end
        bump = 1'b0;
        if (w.kind == drti_pkg::KIND_FLOOR) begin
          bump = w.sign && (sticky || top != 0);
        end else if (w.kind == drti_pkg::KIND_ROUND) begin
          bump = (top > 5) || (top == 5 && (sticky || m[0]));
        end
        if (bump) begin
          m = (m + 96'd1) & drti_pkg::MAG_MASK;
        end
        r.mag   = m;
        r.scale = '0;
      end
    end
    return r;
  endfunction

  function automatic dec_word_t mk_word(drti_pkg::kind_e kind, logic [95:0] mag, int scale,
                                        logic sign, drti_pkg::cls_e cls);
    dec_word_t w;
    w.kind  = kind;
    w.mag   = mag;
    w.scale = 5'(scale);
    w.sign  = sign;
    w.cls   = cls;
    return w;
  endfunction

  task automatic report_mismatch(string field, logic [95:0] got, logic [95:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_LIMIT) begin
      $display("ERROR %0t: %s got %0h expected %0h", $time, field, got, want);
    end
  endtask

  // Sends one word; in burst mode a random gap separates bursts.
  task automatic send_word(dec_word_t w);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, w.sign, w.scale, w.mag};
    s_axis_tuser  <= {w.cls, w.kind};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(round_to_integer(w));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_ALWAYS:  m_axis_tready <= 1'b1;
        SINK_RANDOM:  m_axis_tready <= ($urandom_range(0, 99) < 60);
        default:      m_axis_tready <= sink_pattern[sink_phase];
      endcase
      sink_phase <= sink_phase + 4'd1;
    end
  end

  always @(posedge clk_i) begin
    dec_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata[95:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[63:0] !== want.mag[63:0])
          report_mismatch("res_low", 96'(m_axis_tdata[63:0]), 96'(want.mag[63:0]));
        if (m_axis_tdata[95:64] !== want.mag[95:64])
          report_mismatch("res_high", 96'(m_axis_tdata[95:64]), 96'(want.mag[95:64]));
        if (m_axis_tdata[100:96] !== want.scale)
          report_mismatch("scale_out", 96'(m_axis_tdata[100:96]), 96'(want.scale));
        if (m_axis_tdata[101] !== want.sign)
          report_mismatch("sign_out", 96'(m_axis_tdata[101]), 96'(want.sign));
        if (m_axis_tuser[1:0] !== want.cls)
          report_mismatch("class_out", 96'(m_axis_tuser[1:0]), 96'(want.cls));
      end
    end
  end

  // Extremes, every kind and class, ties, sticky digits, signed zero, scale past 28.
  task automatic test_directed();
    logic [95:0] ones;
    ones = '1;
    sender_gaps = 1'b0;
    sink_mode   = SINK_ALWAYS;
    send_word(mk_word(drti_pkg::KIND_TRUNC, 96'd0, 0, 1'b0, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_TRUNC, ones, 0, 1'b0, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_TRUNC, ones, 28, 1'b0, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_FLOOR, ones, 28, 1'b1, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_ROUND, ones, 28, 1'b0, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_TRUNC, ones, 31, 1'b1, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_ROUND, 96'd5, 31, 1'b0, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_ROUND, 96'd25, 1, 1'b0, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_ROUND, 96'd35, 1, 1'b0, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_ROUND, 96'd15, 1, 1'b1, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_ROUND, 96'd2501, 3, 1'b0, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_ROUND, 96'd2500, 3, 1'b0, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_ROUND, 96'd249, 2, 1'b0, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_ROUND, 96'd5, 1, 1'b1, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_FLOOR, 96'd101, 2, 1'b1, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_FLOOR, 96'd1001, 2, 1'b1, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_FLOOR, 96'd1001, 2, 1'b0, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_FLOOR, 96'd1000, 2, 1'b1, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_TRUNC, 96'd3, 1, 1'b1, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_NEG, 96'd12345, 3, 1'b0, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_NEG, ones, 31, 1'b1, drti_pkg::CLS_NORMAL));
    send_word(mk_word(drti_pkg::KIND_ROUND, 96'd12345, 5, 1'b0, drti_pkg::CLS_PINF));
    send_word(mk_word(drti_pkg::KIND_NEG, 96'd7, 2, 1'b1, drti_pkg::CLS_MINF));
    send_word(mk_word(drti_pkg::KIND_TRUNC, ones, 28, 1'b0, drti_pkg::CLS_NAN));
    send_word(mk_word(drti_pkg::KIND_FLOOR, 96'd99, 0, 1'b1, drti_pkg::CLS_NAN));
    wait_drained();
  endtask

  // Random words in chunks, each chunk with its own idle profile.
  task automatic test_random();
    dec_word_t w;
    int        sel;
    int        digits;
    for (int c = 0; c < RAND_CHUNKS; c++) begin
      if (c % 4 == 0) begin
        sender_gaps = 1'b0;
        sink_mode   = SINK_ALWAYS;
      end else begin
        sender_gaps  = 1'($urandom_range(0, 1));
        sink_mode    = sink_mode_e'($urandom_range(1, 2));
        sink_pattern = 16'($urandom) | 16'h0001;
      end
      burst_left = 0;
      for (int n = 0; n < CHUNK_WORDS; n++) begin
        w.kind = drti_pkg::kind_e'($urandom_range(0, 3));
        w.sign = 1'($urandom_range(0, 1));
        w.cls  = ($urandom_range(0, 9) == 0) ? drti_pkg::cls_e'($urandom_range(1, 3)) :
                 drti_pkg::CLS_NORMAL;
        sel    = $urandom_range(0, 9);
        if (sel <= 2) begin
          w.mag   = {$urandom, $urandom, $urandom};
          w.scale = 5'($urandom_range(0, 28));
        end else if (sel <= 5) begin
          // near a half-way point: q5 followed by zeros, +-1
          digits = $urandom_range(1, 19);
          w.mag  = {64'd0, 32'($urandom)} * 10 + 5;
          repeat (digits - 1) w.mag = w.mag * 10;
          case ($urandom_range(0, 2))
            0:       w.mag = w.mag - 1;
            2:       w.mag = w.mag + 1;
            default: ;
          endcase
          w.scale = 5'(digits);
        end else if (sel <= 7) begin
          w.mag   = 96'($urandom_range(0, 999));
          w.scale = 5'($urandom_range(0, 4));
        end else if (sel == 8) begin
          w.mag   = {$urandom, $urandom, $urandom};
          w.scale = 5'($urandom_range(29, 31));
        end else begin
          w.mag   = $urandom_range(0, 1) ? '1 : '0;
          w.scale = 5'($urandom_range(0, 31));
        end
        send_word(w);
      end
      if (c % 3 == 2) begin
        wait_drained();
      end
    end
    wait_drained();
  endtask

  // Long output stall while the sender keeps offering back to back.
  task automatic test_output_backpressure();
    sender_gaps  = 1'b0;
    sink_mode    = SINK_RANDOM;
    hold_request = HOLD_CYCLES;
    for (int n = 0; n < 24; n++) begin
      send_word(mk_word(drti_pkg::kind_e'($urandom_range(0, 3)),
                        {$urandom, $urandom, $urandom}, $urandom_range(0, 6),
                        1'($urandom_range(0, 1)), drti_pkg::CLS_NORMAL));
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_output_backpressure();
    test_random();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/drti_pkg.sv
rtl/core/drti_div10.sv
rtl/core/drti_seq.sv
rtl/core/decimal_round_to_integer.sv
test/decimal_round_to_integer_tb.sv
